FILE: rtl/qfk_pkg.sv
// Package for the quaternion forward kinematics block.
// Holds widths, the sequencer state type, the control struct and the Hamilton term table.
// Depends on nothing.
package qfk_pkg;

    localparam int QUAT_WIDTH = 16;
    localparam int QFRAC      = QUAT_WIDTH - 2;
    localparam int OFF_WIDTH  = 24;
    localparam int POS_WIDTH  = 32;

    // turned-offset intermediate: 3 * 2^OFF_WIDTH at most
    localparam int TW    = OFF_WIDTH + 3;
    localparam int MW    = (TW > QUAT_WIDTH) ? TW : QUAT_WIDTH;
    localparam int DIG   = 4;
    localparam int NDIG  = (QUAT_WIDTH + DIG - 1) / DIG;
    localparam int MPW   = NDIG * DIG;
    localparam int DIGW  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int PW    = MW + 1 + MPW;
    localparam int ACCW  = PW + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_ROT,
        PH_TURN,
        PH_BACK
    } phase_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic       neg;
    } hterm_t;

    typedef struct packed {
        logic       idle;
        logic       mul;
        logic       fin;
        logic       commit;
        logic       first_dig;
        logic       last_dig;
        phase_t     phase;
        logic [1:0] comp;
        logic [1:0] term;
    } seq_ctrl_t;

    // Hamilton product r = a * b: operand indexes and sign of term k of component j
    function automatic hterm_t hterm(input logic [1:0] j, input logic [1:0] k);
        hterm_t h;
        unique case ({j, k})
            4'h0: h = '{a: 2'd0, b: 2'd0, neg: 1'b0};
            4'h1: h = '{a: 2'd1, b: 2'd1, neg: 1'b1};
            4'h2: h = '{a: 2'd2, b: 2'd2, neg: 1'b1};
            4'h3: h = '{a: 2'd3, b: 2'd3, neg: 1'b1};
            4'h4: h = '{a: 2'd0, b: 2'd1, neg: 1'b0};
            4'h5: h = '{a: 2'd1, b: 2'd0, neg: 1'b0};
            4'h6: h = '{a: 2'd2, b: 2'd3, neg: 1'b0};
            4'h7: h = '{a: 2'd3, b: 2'd2, neg: 1'b1};
            4'h8: h = '{a: 2'd0, b: 2'd2, neg: 1'b0};
            4'h9: h = '{a: 2'd1, b: 2'd3, neg: 1'b1};
            4'hA: h = '{a: 2'd2, b: 2'd0, neg: 1'b0};
            4'hB: h = '{a: 2'd3, b: 2'd1, neg: 1'b0};
            4'hC: h = '{a: 2'd0, b: 2'd3, neg: 1'b0};
            4'hD: h = '{a: 2'd1, b: 2'd2, neg: 1'b0};
            4'hE: h = '{a: 2'd2, b: 2'd1, neg: 1'b1};
            4'hF: h = '{a: 2'd3, b: 2'd0, neg: 1'b0};
        endcase
        return h;
    endfunction

endpackage

FILE: rtl/qfk_if.sv
// Channel interfaces of the forward kinematics block: joint in, pose out.
// Depends on qfk_pkg for field widths.
interface qfk_joint_if;
    import qfk_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          root_joint;
    logic signed [QUAT_WIDTH-1:0]  loc_w;
    logic signed [QUAT_WIDTH-1:0]  loc_x;
    logic signed [QUAT_WIDTH-1:0]  loc_y;
    logic signed [QUAT_WIDTH-1:0]  loc_z;
    logic signed [OFF_WIDTH-1:0]   off_x;
    logic signed [OFF_WIDTH-1:0]   off_y;
    logic signed [OFF_WIDTH-1:0]   off_z;

    modport source (output valid, root_joint, loc_w, loc_x, loc_y, loc_z, off_x, off_y, off_z,
                    input ready);
    modport sink (input valid, root_joint, loc_w, loc_x, loc_y, loc_z, off_x, off_y, off_z,
                  output ready);
endinterface

interface qfk_pose_if;
    import qfk_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [QUAT_WIDTH-1:0]  glob_w;
    logic signed [QUAT_WIDTH-1:0]  glob_x;
    logic signed [QUAT_WIDTH-1:0]  glob_y;
    logic signed [QUAT_WIDTH-1:0]  glob_z;
    logic signed [POS_WIDTH-1:0]   pos_x;
    logic signed [POS_WIDTH-1:0]   pos_y;
    logic signed [POS_WIDTH-1:0]   pos_z;
    logic                          saturated;

    modport source (output valid, glob_w, glob_x, glob_y, glob_z, pos_x, pos_y, pos_z, saturated,
                    input ready);
    modport sink (input valid, glob_w, glob_x, glob_y, glob_z, pos_x, pos_y, pos_z, saturated,
                  output ready);
endinterface

FILE: rtl/qfk_mac.sv
// Digit-serial multiply-accumulate: one multiplier digit per cycle while ctrl.mul is set, MSB first.
// Depends on qfk_pkg.
module qfk_mac
    import qfk_pkg::*;
(
    input  logic                    clk,
    input  seq_ctrl_t               ctrl,
    input  logic signed [MW:0]      mcand_in,
    input  logic signed [QUAT_WIDTH-1:0] mplier_in,
    output logic signed [ACCW-1:0]  acc
);

    logic signed [MW:0]        mcand_reg, mcand_next, cur_mcand;
    logic signed [MPW-1:0]     mplier_reg, mplier_next, cur_mplier, mplier_ext;
    logic signed [PW-1:0]      partial_reg, partial_next, base;
    logic signed [ACCW-1:0]    acc_reg, acc_next;
    logic [DIG-1:0]            dig;
    logic signed [DIG:0]       dig_val;
    logic signed [MW+DIG+1:0]  prod;

    always_comb
    begin
        mplier_ext   = MPW'(mplier_in);
        cur_mcand    = ctrl.first_dig ? mcand_in : mcand_reg;
        cur_mplier   = ctrl.first_dig ? mplier_ext : mplier_reg;
        dig          = cur_mplier[MPW-1 -: DIG];
        // top digit carries the sign, the rest are plain
        dig_val      = ctrl.first_dig ? {dig[DIG-1], dig} : {1'b0, dig};
        prod         = cur_mcand * dig_val;
        base         = ctrl.first_dig ? '0 : partial_reg;
        partial_next = (base <<< DIG) + PW'(prod);
        mplier_next  = cur_mplier << DIG;
        mcand_next   = cur_mcand;
        if (ctrl.mul && ctrl.last_dig)
        begin
            acc_next = acc_reg + ACCW'(partial_next);
        end
        else if (ctrl.mul)
        begin
            acc_next = acc_reg;
        end
        else
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            mcand_reg   <= mcand_next;
            mplier_reg  <= mplier_next;
            partial_reg <= partial_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/qfk_seq.sv
// Sequencer: walks phase, component, term and digit for the shared digit-serial MAC.
// Depends on qfk_pkg.
module qfk_seq
    import qfk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start_run,
    input  logic      start_root,
    input  logic      out_free,
    output seq_ctrl_t ctrl
);

    seq_state_t       state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       comp_reg, comp_next;
    logic [1:0]       term_reg, term_next;
    logic [DIGW-1:0]  dig_reg, dig_next;
    logic             last_dig;

    assign last_dig = (dig_reg == DIGW'(NDIG - 1));

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        comp_next  = comp_reg;
        term_next  = term_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                phase_next = PH_ROT;
                comp_next  = 2'd0;
                term_next  = 2'd0;
                dig_next   = '0;
                if (start_root)
                begin
                    state_next = ST_DONE;
                end
                else if (start_run)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (last_dig)
                begin
                    dig_next  = '0;
                    term_next = term_reg + 2'd1;
                    if (term_reg == 2'd3)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    dig_next = dig_reg + DIGW'(1);
                end
            end
            ST_FIN:
            begin
                state_next = ST_MUL;
                if (comp_reg == 2'd3)
                begin
                    unique case (phase_reg)
                        PH_ROT:
                        begin
                            phase_next = PH_TURN;
                            comp_next  = 2'd0;
                        end
                        PH_TURN:
                        begin
                            // the scalar part of the back-turn is dropped
                            phase_next = PH_BACK;
                            comp_next  = 2'd1;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.idle      = (state_reg == ST_IDLE);
        ctrl.mul       = (state_reg == ST_MUL);
        ctrl.fin       = (state_reg == ST_FIN);
        ctrl.commit    = (state_reg == ST_DONE) && out_free;
        ctrl.first_dig = (dig_reg == '0);
        ctrl.last_dig  = last_dig;
        ctrl.phase     = phase_reg;
        ctrl.comp      = comp_reg;
        ctrl.term      = term_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_ROT;
            comp_reg  <= 2'd0;
            term_reg  <= 2'd0;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            term_reg  <= term_next;
            dig_reg   <= dig_next;
        end
    end

endmodule

FILE: rtl/quaternion_forward_kinematics.sv
// Forward kinematics of a joint chain, one joint per transfer, on one digit-serial MAC.
// A root joint goes straight to the done state; other joints run 11 components (4 terms x
// NDIG digits each, then a rounding step) on the 4-bit-per-cycle shared MAC.
// Joints are not overlapped: the next joint is taken once the last one is done, even
// while the previous pose still waits in the output register.
// Reset: prev rotation is the identity, prev position zero, output empty.
module quaternion_forward_kinematics
    import qfk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    qfk_joint_if.sink  joint,
    qfk_pose_if.source pose
);

    localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(1) <<< (QFRAC - 1);
    localparam logic signed [ACCW-1:0] QMAX     = (ACCW'(1) <<< (QUAT_WIDTH - 1)) - ACCW'(1);
    localparam logic signed [ACCW-1:0] QMIN     = -(ACCW'(1) <<< (QUAT_WIDTH - 1));
    localparam logic signed [ACCW:0]   PMAX     = ((ACCW+1)'(1) <<< (POS_WIDTH - 1))
                                                  - (ACCW+1)'(1);
    localparam logic signed [ACCW:0]   PMIN     = -((ACCW+1)'(1) <<< (POS_WIDTH - 1));

    seq_ctrl_t ctrl;
    logic      accept;
    logic      out_free;

    // item and chain state
    logic signed [QUAT_WIDTH-1:0] loc_reg [4];
    logic signed [OFF_WIDTH-1:0]  off_reg [3];
    logic signed [QUAT_WIDTH-1:0] prev_rot_reg [4];
    logic signed [POS_WIDTH-1:0]  prev_pos_reg [3];
    logic signed [QUAT_WIDTH-1:0] glob_reg [4];
    logic signed [TW-1:0]         t_reg [4];
    logic                         flag_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [QUAT_WIDTH-1:0] out_glob_reg [4];
    logic signed [POS_WIDTH-1:0]  out_pos_reg [3];
    logic                         out_sat_reg;

    // operand selection
    hterm_t                       ht;
    logic                         neg;
    logic signed [MW:0]           mcand_sel, mcand_in;
    logic signed [QUAT_WIDTH-1:0] mplier_in;
    logic signed [ACCW-1:0]       acc;

    // rounding and saturation
    logic signed [ACCW-1:0]       rnd;
    logic signed [QUAT_WIDTH-1:0] rot_sat;
    logic                         rot_ovf;
    logic signed [POS_WIDTH-1:0]  pos_prev_sel;
    logic signed [ACCW:0]         psum;
    logic signed [POS_WIDTH-1:0]  pos_sat;
    logic                         pos_ovf;
    logic [1:0]                   pos_idx;

    assign joint.ready = ctrl.idle;
    assign accept      = joint.valid && joint.ready;
    assign out_free    = !out_valid_reg || pose.ready;

    qfk_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_run  (accept && !joint.root_joint),
        .start_root (accept && joint.root_joint),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // Pick multiplier (always a rotation component) and multiplicand for this term.
    // Rotate phase:  prev_rot * loc.  Turn phase: glob * (0, off).
    // Back phase:    t * conj(glob), the conjugate folded into the term sign.
    always_comb
    begin
        ht  = hterm(ctrl.comp, ctrl.term);
        neg = ht.neg;
        unique case (ctrl.phase)
            PH_ROT:
            begin
                mplier_in = prev_rot_reg[ht.a];
                mcand_sel = (MW+1)'(loc_reg[ht.b]);
            end
            PH_TURN:
            begin
                mplier_in = glob_reg[ht.a];
                unique case (ht.b)
                    2'd1:    mcand_sel = (MW+1)'(off_reg[0]);
                    2'd2:    mcand_sel = (MW+1)'(off_reg[1]);
                    2'd3:    mcand_sel = (MW+1)'(off_reg[2]);
                    default: mcand_sel = '0;
                endcase
            end
            default:
            begin
                mplier_in = glob_reg[ht.b];
                mcand_sel = (MW+1)'(t_reg[ht.a]);
                neg       = ht.neg ^ (ht.b != 2'd0);
            end
        endcase
        mcand_in = neg ? -mcand_sel : mcand_sel;
    end

    qfk_mac u_mac (
        .clk       (clk),
        .ctrl      (ctrl),
        .mcand_in  (mcand_in),
        .mplier_in (mplier_in),
        .acc       (acc)
    );

    // Round to nearest, ties up, then clamp per phase.
    always_comb
    begin
        rnd = (acc + RND_HALF) >>> QFRAC;

        rot_ovf = 1'b0;
        if (rnd > QMAX)
        begin
            rot_sat = QUAT_WIDTH'(QMAX);
            rot_ovf = 1'b1;
        end
        else if (rnd < QMIN)
        begin
            rot_sat = QUAT_WIDTH'(QMIN);
            rot_ovf = 1'b1;
        end
        else
        begin
            rot_sat = rnd[QUAT_WIDTH-1:0];
        end

        pos_idx = ctrl.comp - 2'd1;
        unique case (pos_idx)
            2'd1:    pos_prev_sel = prev_pos_reg[1];
            2'd2:    pos_prev_sel = prev_pos_reg[2];
            default: pos_prev_sel = prev_pos_reg[0];
        endcase
        psum    = (ACCW+1)'(pos_prev_sel) + (ACCW+1)'(rnd);
        pos_ovf = 1'b0;
        if (psum > PMAX)
        begin
            pos_sat = POS_WIDTH'(PMAX);
            pos_ovf = 1'b1;
        end
        else if (psum < PMIN)
        begin
            pos_sat = POS_WIDTH'(PMIN);
            pos_ovf = 1'b1;
        end
        else
        begin
            pos_sat = psum[POS_WIDTH-1:0];
        end
    end

    // Working registers: capture the joint, store each finished component,
    // commit the chain rotation when the pose moves to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_rot_reg[0] <= QUAT_WIDTH'(1) <<< QFRAC;
            prev_rot_reg[1] <= '0;
            prev_rot_reg[2] <= '0;
            prev_rot_reg[3] <= '0;
            prev_pos_reg[0] <= '0;
            prev_pos_reg[1] <= '0;
            prev_pos_reg[2] <= '0;
            flag_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                flag_reg <= 1'b0;
                if (joint.root_joint)
                begin
                    // root: take the joint as it stands
                    prev_pos_reg[0] <= POS_WIDTH'(joint.off_x);
                    prev_pos_reg[1] <= POS_WIDTH'(joint.off_y);
                    prev_pos_reg[2] <= POS_WIDTH'(joint.off_z);
                end
            end
            if (ctrl.fin)
            begin
                if (ctrl.phase == PH_ROT && rot_ovf)
                begin
                    flag_reg <= 1'b1;
                end
                if (ctrl.phase == PH_BACK)
                begin
                    prev_pos_reg[pos_idx] <= pos_sat;
                    if (pos_ovf)
                    begin
                        flag_reg <= 1'b1;
                    end
                end
            end
            if (ctrl.commit)
            begin
                prev_rot_reg <= glob_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            loc_reg[0] <= joint.loc_w;
            loc_reg[1] <= joint.loc_x;
            loc_reg[2] <= joint.loc_y;
            loc_reg[3] <= joint.loc_z;
            off_reg[0] <= joint.off_x;
            off_reg[1] <= joint.off_y;
            off_reg[2] <= joint.off_z;
            if (joint.root_joint)
            begin
                glob_reg[0] <= joint.loc_w;
                glob_reg[1] <= joint.loc_x;
                glob_reg[2] <= joint.loc_y;
                glob_reg[3] <= joint.loc_z;
            end
        end
        if (ctrl.fin)
        begin
            unique case (ctrl.phase)
                PH_ROT:  glob_reg[ctrl.comp] <= rot_sat;
                PH_TURN: t_reg[ctrl.comp]    <= rnd[TW-1:0];
                default: ;
            endcase
        end
    end

    // Output register: hold the pose until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pose.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_glob_reg <= glob_reg;
            out_pos_reg  <= prev_pos_reg;
            out_sat_reg  <= flag_reg;
        end
    end

    assign pose.valid     = out_valid_reg;
    assign pose.glob_w    = out_glob_reg[0];
    assign pose.glob_x    = out_glob_reg[1];
    assign pose.glob_y    = out_glob_reg[2];
    assign pose.glob_z    = out_glob_reg[3];
    assign pose.pos_x     = out_pos_reg[0];
    assign pose.pos_y     = out_pos_reg[1];
    assign pose.pos_z     = out_pos_reg[2];
    assign pose.saturated = out_sat_reg;

endmodule

FILE: bench/tb_qfk_if.sv
`timescale 1ns / 100ps
// Testbench copy point for the channel interfaces is the RTL file rtl/qfk_if.sv;
// this file holds the joint/pose transfer record types used by the bench.
// Depends on qfk_pkg.
package tb_qfk_types;
    import qfk_pkg::*;

    typedef struct {
        logic                         root_joint;
        logic signed [QUAT_WIDTH-1:0] loc[4];
        logic signed [OFF_WIDTH-1:0]  off[3];
    } joint_t;

    typedef struct {
        logic signed [QUAT_WIDTH-1:0] glob[4];
        logic signed [POS_WIDTH-1:0]  pos[3];
        logic                         saturated;
    } pose_t;
endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench for quaternion_forward_kinematics: random and directed joint chains,
// a fixed-point pose predictor, and a scoreboard on the pose channel.
// Depends on qfk_pkg, tb_qfk_types and the channel interfaces.
module tb_top;
    import qfk_pkg::*;
    import tb_qfk_types::*;

    localparam int N_RANDOM    = 1900;
    localparam longint LIMIT   = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    qfk_joint_if joint();
    qfk_pose_if  pose();

    quaternion_forward_kinematics dut (
        .clk   (clk),
        .rst_n (rst_n),
        .joint (joint.sink),
        .pose  (pose.source)
    );

    // chain state of the predictor
    longint chain_rot[4];
    longint chain_pos[3];

    joint_t joint_queue[$];
    pose_t  pose_queue[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches = 0;
    longint cycles = 0;

    // Arithmetic shift right on a 64-bit signed value.
    function automatic longint ashr(longint x, int s);
        return x >>> s;
    endfunction

    // Round (p0+p1+p2+p3) / 2^s to nearest, ties upward; split so the sum never wraps.
    function automatic longint round_sum(longint p0, longint p1, longint p2, longint p3,
                                         int s);
        longint hi;
        longint lo;
        hi = ashr(p0, 2) + ashr(p1, 2) + ashr(p2, 2) + ashr(p3, 2);
        lo = (p0 & 3) + (p1 & 3) + (p2 & 3) + (p3 & 3);
        return ashr(hi + (longint'(1) <<< (s - 3)) + lo / 4, s - 2);
    endfunction

    // Hamilton product a * b with rounding back by s fraction bits.
    function automatic void hamilton(input longint a[4], input longint b[4], input int s,
                                     output longint r[4]);
        r[0] = round_sum(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]), s);
        r[1] = round_sum(a[0]*b[1], a[1]*b[0], a[2]*b[3], -(a[3]*b[2]), s);
        r[2] = round_sum(a[0]*b[2], -(a[1]*b[3]), a[2]*b[0], a[3]*b[1], s);
        r[3] = round_sum(a[0]*b[3], a[1]*b[2], -(a[2]*b[1]), a[3]*b[0], s);
    endfunction

    function automatic longint clamp(longint v, int w, inout bit flag);
        longint top;
        longint bot;
        top = (longint'(1) <<< (w - 1)) - 1;
        bot = -top - 1;
        if (v > top)
        begin
            flag = 1'b1;
            return top;
        end
        if (v < bot)
        begin
            flag = 1'b1;
            return bot;
        end
        return v;
    endfunction

    // Advance the chain by one joint and return the pose it yields.
    function automatic pose_t predict_pose(joint_t j);
        pose_t  p;
        longint loc[4];
        longint g[4];
        longint raw[4];
        longint v[4];
        longint t[4];
        longint c[4];
        longint r[4];
        bit     flag;
        flag = 1'b0;
        for (int i = 0; i < 4; i++)
            loc[i] = j.loc[i];
        if (j.root_joint)
        begin
            for (int i = 0; i < 4; i++)
                g[i] = loc[i];
            for (int i = 0; i < 3; i++)
                chain_pos[i] = j.off[i];
        end
        else
        begin
            hamilton(chain_rot, loc, QFRAC, raw);
            for (int i = 0; i < 4; i++)
                g[i] = clamp(raw[i], QUAT_WIDTH, flag);
            v[0] = 0;
            for (int i = 0; i < 3; i++)
                v[i + 1] = j.off[i];
            hamilton(g, v, QFRAC, t);
            c[0] = g[0];
            for (int i = 1; i < 4; i++)
                c[i] = -g[i];
            hamilton(t, c, QFRAC, r);
            for (int i = 0; i < 3; i++)
                chain_pos[i] = clamp(chain_pos[i] + r[i + 1], POS_WIDTH, flag);
        end
        for (int i = 0; i < 4; i++)
        begin
            chain_rot[i] = g[i];
            p.glob[i] = g[i][QUAT_WIDTH-1:0];
        end
        for (int i = 0; i < 3; i++)
            p.pos[i] = chain_pos[i][POS_WIDTH-1:0];
        p.saturated = flag;
        return p;
    endfunction

    function automatic joint_t make_joint(bit root, longint w, longint x, longint y,
                                          longint z, longint ox, longint oy, longint oz);
        joint_t j;
        j.root_joint = root;
        j.loc[0] = w[QUAT_WIDTH-1:0];
        j.loc[1] = x[QUAT_WIDTH-1:0];
        j.loc[2] = y[QUAT_WIDTH-1:0];
        j.loc[3] = z[QUAT_WIDTH-1:0];
        j.off[0] = ox[OFF_WIDTH-1:0];
        j.off[1] = oy[OFF_WIDTH-1:0];
        j.off[2] = oz[OFF_WIDTH-1:0];
        return j;
    endfunction

    // Rotation component: small jitter around zero, or any 16-bit value when wide.
    function automatic longint rand_quat_part(bit wide);
        if (wide)
            return $signed(16'($urandom));
        return longint'($urandom_range(0, 1 << (QFRAC - 1))) - (1 << (QFRAC - 2));
    endfunction

    function automatic longint rand_off(bit wide);
        if (wide)
            return $signed(24'($urandom));
        return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    function automatic joint_t rand_joint();
        bit     wide;
        bit     root;
        longint q[4];
        wide = ($urandom_range(0, 9) == 0);
        root = ($urandom_range(0, 7) == 0);
        q[0] = wide ? rand_quat_part(1) : (1 << QFRAC) - $urandom_range(0, 1 << (QFRAC - 2));
        for (int i = 1; i < 4; i++)
            q[i] = rand_quat_part(wide);
        return make_joint(root, q[0], q[1], q[2], q[3],
                          rand_off($urandom_range(0, 9) == 0),
                          rand_off($urandom_range(0, 9) == 0),
                          rand_off($urandom_range(0, 9) == 0));
    endfunction

    // Driver: present the head of the pending queue, idle at random between transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint.valid      <= 1'b0;
            joint.root_joint <= 1'b0;
            joint.loc_w      <= '0;
            joint.loc_x      <= '0;
            joint.loc_y      <= '0;
            joint.loc_z      <= '0;
            joint.off_x      <= '0;
            joint.off_y      <= '0;
            joint.off_z      <= '0;
        end
        else
        begin
            if (joint.valid && joint.ready)
            begin
                // transfer accepted: predict now, in acceptance order
                pose_queue.push_back(predict_pose(joint_queue.pop_front()));
            end
            if (!joint.valid || joint.ready)
            begin
                if (joint_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    joint.valid      <= 1'b1;
                    joint.root_joint <= joint_queue[0].root_joint;
                    joint.loc_w      <= joint_queue[0].loc[0];
                    joint.loc_x      <= joint_queue[0].loc[1];
                    joint.loc_y      <= joint_queue[0].loc[2];
                    joint.loc_z      <= joint_queue[0].loc[3];
                    joint.off_x      <= joint_queue[0].off[0];
                    joint.off_y      <= joint_queue[0].off[1];
                    joint.off_z      <= joint_queue[0].off[2];
                end
                else
                    joint.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the pose channel at random and score every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        pose_t exp_pose;
        bit    bad;
        if (!rst_n)
            pose.ready <= 1'b0;
        else
        begin
            if (pose.valid && pose.ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pose transfer at cycle %0d", cycles);
                end
                else
                begin
                    exp_pose = pose_queue.pop_front();
                    bad = (pose.glob_w !== exp_pose.glob[0]) ||
                          (pose.glob_x !== exp_pose.glob[1]) ||
                          (pose.glob_y !== exp_pose.glob[2]) ||
                          (pose.glob_z !== exp_pose.glob[3]) ||
                          (pose.pos_x !== exp_pose.pos[0]) ||
                          (pose.pos_y !== exp_pose.pos[1]) ||
                          (pose.pos_z !== exp_pose.pos[2]) ||
                          (pose.saturated !== exp_pose.saturated);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pose mismatch cycle %0d: ", cycles,
                                     "exp q=%0d %0d %0d %0d p=%0d %0d %0d s=%0b ",
                                     exp_pose.glob[0], exp_pose.glob[1],
                                     exp_pose.glob[2], exp_pose.glob[3], exp_pose.pos[0],
                                     exp_pose.pos[1], exp_pose.pos[2], exp_pose.saturated,
                                     "got q=%0d %0d %0d %0d p=%0d %0d %0d s=%0b",
                                     pose.glob_w, pose.glob_x, pose.glob_y, pose.glob_z,
                                     pose.pos_x, pose.pos_y, pose.pos_z, pose.saturated);
                    end
                end
            end
            pose.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run at a generous cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        for (int i = 0; i < 4; i++)
            chain_rot[i] = 0;
        chain_rot[0] = 1 << QFRAC;
        for (int i = 0; i < 3; i++)
            chain_pos[i] = 0;
        send_idle_pct = 30;
        recv_idle_pct = 76;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: chain off the reset state, identity, extremes, saturation, root reset.
        joint_queue.push_back(make_joint(0, 1 << QFRAC, 0, 0, 0, 1 << 16, 2 << 16, 3 << 16));
        joint_queue.push_back(make_joint(0, 0, 1 << QFRAC, 0, 0, 1 << 16, 0, 0));
        joint_queue.push_back(make_joint(1, 32767, -32768, 32767, -32768,
                                         8388607, -8388608, 0));
        joint_queue.push_back(make_joint(0, 32767, 32767, 32767, 32767,
                                         8388607, 8388607, 8388607));
        joint_queue.push_back(make_joint(0, -32768, -32768, -32768, -32768,
                                         -8388608, -8388608, -8388608));
        joint_queue.push_back(make_joint(1, -32768, 0, 0, 0, -8388608, 8388607, -1));
        for (int i = 0; i < 8; i++)
            joint_queue.push_back(make_joint(0, 32767, 32767, -32768, 32767,
                                             8388607, 8388607, 8388607));
        joint_queue.push_back(make_joint(1, 0, 0, 0, 0, 0, 0, 0));
        joint_queue.push_back(make_joint(0, 0, 0, 0, 0, -1, -1, -1));
        joint_queue.push_back(make_joint(1, 1 << QFRAC, 0, 0, 0, 0, 0, 0));
        joint_queue.push_back(make_joint(0, 0, 0, 1 << QFRAC, 0, 5, -7, 11));
        joint_queue.push_back(make_joint(0, 0, 0, 0, -(1 << QFRAC), -3, 1, 1));
        joint_queue.push_back(make_joint(0, 11585, 11585, 0, 0, 1 << 16, 1 << 16, 1 << 16));

        // Random chains in three idling phases.
        for (int ph = 0; ph < 3; ph++)
        begin
            n = (ph == 2) ? N_RANDOM - 2 * (N_RANDOM / 3) : N_RANDOM / 3;
            for (int i = 0; i < n; i++)
                joint_queue.push_back(rand_joint());
            wait (joint_queue.size() == 0);
            @(posedge clk);
            if (ph == 0)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        // Drain the pose channel, then let trailing activity settle.
        wait (pose_queue.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && pose_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
